FILE: src/pwes_pkg.sv
// Shared types and constants for the packed word element sorter.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps
`default_nettype none

package pwes_pkg;

    localparam int WORD_W     = 64;
    localparam int NUM_LANES  = 16;
    localparam int ELEM_W     = 8;
    localparam int NIBBLE_W   = 4;
    localparam int BYTE_LANES = WORD_W / ELEM_W;
    localparam int RANK_W     = $clog2(NUM_LANES);

    // element size selector codes
    localparam logic MODE_BYTE   = 1'b0;
    localparam logic MODE_NIBBLE = 1'b1;

    typedef logic [NUM_LANES-1:0][ELEM_W-1:0] elem_arr_t;
    typedef logic [NUM_LANES-1:0][RANK_W-1:0] rank_arr_t;

    // one word on its way through the lanes
    typedef struct packed {
        logic                 mode;
        logic [NUM_LANES-1:0] active;
        elem_arr_t            elems;
    } stage_t;

endpackage

`default_nettype wire

FILE: src/pwes_lane.sv
// One rank lane: counts how many elements of the word sort below its own.
// Depends on pwes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwes_lane
    import pwes_pkg::*;
#(
    parameter int LANE_IDX = 0
)
(
    input  var stage_t            stage,
    output logic [RANK_W-1:0]     rank
);

    logic [NUM_LANES-1:0] below;

    // ties go to the lower index so every active lane gets a distinct rank
    always_comb
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            if (j < LANE_IDX)
                below[j] = stage.active[j] && (stage.elems[j] <= stage.elems[LANE_IDX]);
            else if (j > LANE_IDX)
                below[j] = stage.active[j] && (stage.elems[j] < stage.elems[LANE_IDX]);
            else
                below[j] = 1'b0;
        end
    end

    assign rank = RANK_W'($countones(below));

endmodule

`default_nettype wire

FILE: src/pwes_merge.sv
// Merge stage: drops each lane's element into the slot named by its rank
// and packs the slots back into a word. Depends on pwes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwes_merge
    import pwes_pkg::*;
(
    input  var stage_t            stage,
    input  var rank_arr_t         ranks,
    output logic [WORD_W-1:0]     word
);

    elem_arr_t slots;

    always_comb
    begin
        for (int p = 0; p < NUM_LANES; p++)
        begin
            slots[p] = '0;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                if (stage.active[i] && (ranks[i] == RANK_W'(p)))
                    slots[p] = slots[p] | stage.elems[i];
            end
        end
    end

    always_comb
    begin
        word = '0;
        case (stage.mode)
            MODE_BYTE:
            begin
                for (int p = 0; p < BYTE_LANES; p++)
                    word[p*ELEM_W +: ELEM_W] = slots[p];
            end
            MODE_NIBBLE:
            begin
                for (int p = 0; p < NUM_LANES; p++)
                    word[p*NIBBLE_W +: NIBBLE_W] = slots[p][NIBBLE_W-1:0];
            end
            default:
            begin
                word = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/packed_word_element_sort.sv
// Top level of the packed word element sorter: unpack, rank lanes, merge.
// Depends on pwes_pkg, pwes_lane and pwes_merge.
`timescale 1ns / 1ps
`default_nettype none

// Sorts the eight bytes (cfg_wr_data = 0) or sixteen nibbles (cfg_wr_data = 1)
// of each 64-bit input word by unsigned value, smallest in the least significant
// position. One word is taken every cycle unless the output stalls. Each word
// passes three register stages, the first loaded by the edge that takes it: unpack,
// sixteen parallel rank lanes (each compares its element against all others), and
// the merge that places every element at its rank. The whole pipeline holds while
// the output word waits for m_axis_tready. Write the element size only while no
// word is in flight.
module packed_word_element_sort
    import pwes_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,

    input  wire                 cfg_wr_en,
    input  wire                 cfg_wr_data,    // element_size_mode

    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire  [WORD_W-1:0]   s_axis_tdata,   // [63:0] packed_word

    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [WORD_W-1:0]   m_axis_tdata    // [63:0] sorted_word
);

    logic              mode_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    stage_t            s1_reg;
    stage_t            s2_reg;
    rank_arr_t         rank_reg;
    logic              mode3_reg;
    logic [WORD_W-1:0] out_reg;

    stage_t            s1_next;
    rank_arr_t         rank_next;
    logic [WORD_W-1:0] out_next;
    logic              advance;

    assign advance       = !v3_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_BYTE;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    // split the word into lanes; byte mode leaves the upper lanes idle
    always_comb
    begin
        s1_next.mode = mode_reg;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (mode_reg == MODE_NIBBLE)
            begin
                s1_next.elems[i]  = {{(ELEM_W-NIBBLE_W){1'b0}},
                                     s_axis_tdata[i*NIBBLE_W +: NIBBLE_W]};
                s1_next.active[i] = 1'b1;
            end
            else if (i < BYTE_LANES)
            begin
                s1_next.elems[i]  = s_axis_tdata[(i%BYTE_LANES)*ELEM_W +: ELEM_W];
                s1_next.active[i] = 1'b1;
            end
            else
            begin
                s1_next.elems[i]  = '0;
                s1_next.active[i] = 1'b0;
            end
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        pwes_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .stage (s1_reg),
            .rank  (rank_next[g])
        );
    end

    pwes_merge u_merge (
        .stage (s2_reg),
        .ranks (rank_reg),
        .word  (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg    <= s1_next;
            s2_reg    <= s1_reg;
            rank_reg  <= rank_next;
            mode3_reg <= s2_reg.mode;
            out_reg   <= out_next;
        end
    end

    // checks
    logic [NUM_LANES-1:0] rank_seen;
    logic                 sorted_ok;

    always_comb
    begin
        rank_seen = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (s2_reg.active[i])
                rank_seen[rank_reg[i]] = 1'b1;
        end
    end

    always_comb
    begin
        sorted_ok = 1'b1;
        if (mode3_reg == MODE_NIBBLE)
        begin
            for (int p = 0; p < NUM_LANES - 1; p++)
                if (out_reg[p*NIBBLE_W +: NIBBLE_W] > out_reg[(p+1)*NIBBLE_W +: NIBBLE_W])
                    sorted_ok = 1'b0;
        end
        else
        begin
            for (int p = 0; p < BYTE_LANES - 1; p++)
                if (out_reg[p*ELEM_W +: ELEM_W] > out_reg[(p+1)*ELEM_W +: ELEM_W])
                    sorted_ok = 1'b0;
        end
    end

    a_rank_perm: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (rank_seen == s2_reg.active))
        else $error("rank lanes did not produce a permutation");

    a_out_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> sorted_ok)
        else $error("output word not in ascending order");

    a_pipe_move: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && v2_reg) |=> v3_reg)
        else $error("word lost between merge and output register");

    a_take_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted word not captured in first stage");

endmodule

`default_nettype wire

FILE: tb/tb_packed_word_element_sort.sv
// Testbench for packed_word_element_sort: byte and nibble sorting of 64-bit words.
// Depends on pwes_pkg and the RTL under src; expected words come from a counting-sort
// predictor, checked in order against the output stream.
`timescale 1ns / 1ps

module tb_packed_word_element_sort
    import pwes_pkg::*;
;

    localparam int STUCK_LIMIT = 2000;   // cycles with no word moving on either side
    localparam int DRAIN_PAD   = 10;     // pipeline is three stages deep

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic              cfg_wr_data   = MODE_BYTE;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [WORD_W-1:0] m_axis_tdata;

    logic              size_mode = MODE_BYTE;   // mirror of the element size register
    logic [WORD_W-1:0] pending_sorted[$];
    logic [WORD_W-1:0] expected_word;
    int                mismatches = 0;
    int                stuck_cycles = 0;

    // sender bursts
    bit                gaps_on    = 1'b1;
    int                burst_left = 0;

    // receiver stall control
    int                rx_style   = 0;      // 0 always ready, 1 random, 2 rotating pattern
    logic [7:0]        rx_pattern = 8'b1011_0010;
    int                hold_req   = 0;
    int                hold_left  = 0;

    packed_word_element_sort u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Counting sort: tally each element value, then lay the values out from the low end.
    function automatic logic [WORD_W-1:0] sort_elements(input logic [WORD_W-1:0] w,
                                                        input logic mode);
        int unsigned       width;
        int unsigned       lanes;
        int unsigned       pos;
        int unsigned       tally[256];
        logic [7:0]        mask;
        logic [WORD_W-1:0] sorted;
        width = (mode == MODE_NIBBLE) ? NIBBLE_W : ELEM_W;
        lanes = WORD_W / width;
        mask  = 8'((1 << width) - 1);
        foreach (tally[v])
            tally[v] = 0;
        for (int i = 0; i < lanes; i++)
            tally[8'(w >> (i * width)) & mask]++;
        sorted = '0;
        pos    = 0;
        for (int v = 0; v <= mask; v++)
        begin
            repeat (tally[v])
            begin
                sorted |= 64'(v) << (pos * width);
                pos++;
            end
        end
        return sorted;
    endfunction

    // Mix of fully random words, words built from a few repeated values, words of
    // only the extreme values, and words already in order.
    function automatic logic [WORD_W-1:0] random_word(input logic mode);
        int unsigned       width;
        int unsigned       lanes;
        int unsigned       kind;
        logic [7:0]        top;
        logic [7:0]        pool[3];
        logic [7:0]        elem;
        logic [WORD_W-1:0] w;
        width = (mode == MODE_NIBBLE) ? NIBBLE_W : ELEM_W;
        lanes = WORD_W / width;
        top   = 8'((1 << width) - 1);
        kind  = $urandom_range(0, 3);
        w     = {$urandom, $urandom};
        foreach (pool[k])
            pool[k] = 8'($urandom) & top;
        if (kind == 1 || kind == 2)
        begin
            w = '0;
            for (int i = 0; i < lanes; i++)
            begin
                if (kind == 1)
                    elem = pool[$urandom_range(0, 2)];
                else
                    elem = $urandom_range(0, 1) ? top : 8'h00;
                w |= 64'(elem) << (i * width);
            end
        end
        else if (kind == 3)
            w = sort_elements(w, mode);
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Offer one word, hold it until taken, and record its expected sorted form.
    task automatic send_word(input logic [WORD_W-1:0] w);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_sorted.push_back(sort_elements(w, size_mode));
    endtask

    // Drain the pipeline, then write the element size.
    task automatic set_size_mode(input logic mode);
        s_axis_tvalid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        size_mode = mode;
    endtask

    task automatic test_reset_byte_mode();
        logic [WORD_W-1:0] words[$];
        gaps_on  = 1'b0;
        rx_style = 0;
        words = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0706_0504_0302_0100,
                  64'h0001_0203_0405_0607, 64'h0123_4567_89AB_CDEF, 64'h8000_0000_0000_0001,
                  64'h00FF_00FF_00FF_00FF, 64'h7F80_7F80_0000_FFFF, 64'h5555_AAAA_3C3C_C3C3,
                  64'hFF00_0000_0000_0000};
        foreach (words[i])
            send_word(words[i]);
    endtask

    task automatic test_nibble_mode();
        logic [WORD_W-1:0] words[$];
        set_size_mode(MODE_NIBBLE);
        words = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFEDC_BA98_7654_3210,
                  64'h0123_4567_89AB_CDEF, 64'hF000_0000_0000_000F, 64'h5A5A_5A5A_5A5A_5A5A,
                  64'h8421_8421_1248_1248, 64'h0000_0000_0000_0007, 64'h9999_6666_9999_6666};
        foreach (words[i])
            send_word(words[i]);
        set_size_mode(MODE_BYTE);
        send_word(64'h0123_4567_89AB_CDEF);
        set_size_mode(MODE_BYTE);
        send_word(64'hFEDC_BA98_7654_3210);
    endtask

    task automatic test_random_words(input logic mode, input int count, input int style,
                                     input bit gaps);
        set_size_mode(mode);
        rx_style = style;
        gaps_on  = gaps;
        repeat (count)
            send_word(random_word(mode));
    endtask

    // Hold the output long enough that the pipeline fills and the input stalls.
    task automatic test_output_backpressure(input logic mode);
        set_size_mode(mode);
        rx_style = 0;
        gaps_on  = 1'b0;
        hold_req = 300;
        repeat (40)
            send_word(random_word(mode));
    endtask

    // receiver: long hold first, otherwise the current stall style
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_style == 1)
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        else if (rx_style == 2)
            m_axis_tready <= rx_pattern[0];
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_sorted.size() == 0)
                report_mismatch("unexpected sorted_word", m_axis_tdata, 'x);
            else
            begin
                expected_word = pending_sorted.pop_front();
                if (m_axis_tdata !== expected_word)
                    report_mismatch("sorted_word", m_axis_tdata, expected_word);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles = 0;
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_byte_mode();
        test_nibble_mode();
        test_random_words(MODE_BYTE, 400, 1, 1'b1);
        test_random_words(MODE_NIBBLE, 400, 2, 1'b1);
        test_output_backpressure(MODE_NIBBLE);
        test_random_words(MODE_BYTE, 300, 0, 1'b0);
        test_random_words(MODE_NIBBLE, 300, 1, 1'b0);
        test_random_words(MODE_BYTE, 100, 2, 1'b1);

        s_axis_tvalid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
